// File: design/gvcs_pkg.sv
// ----------------------------------------------------------------------------
// gvcs_pkg: shared types and constants for the grid clearance search core
// Op codes, register indexes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package gvcs_pkg;

    localparam int POS_W   = 24;
    localparam int DIST_W  = 18;
    localparam int SIZE_W  = 9;
    localparam int CLASS_W = 8;
    localparam int CELL_W  = 8;
    localparam int OFF_W   = 12;
    localparam int VAL_W   = 26;
    localparam int SQ_W    = 24;
    localparam int RAD_W   = 42;
    localparam int RAD_SH  = 18;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_CHECK  = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] CFG_SIZE_X   = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y   = 2'd1;
    localparam logic [1:0] CFG_OBSTACLE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_SQX,
        S_SQY,
        S_SQRT,
        S_DONE
    } state_t;

endpackage

// File: design/grid_validity_clearance_search_core.sv
// ----------------------------------------------------------------------------
// grid_validity_clearance_search_core: occupancy grid check and spiral search
// Stores a class grid, checks position validity and searches a square spiral
// for the first validity change on it, then takes the distance by a bit-serial root.
// ----------------------------------------------------------------------------
//  channel | signals                                          | transfer when
//  --------+--------------------------------------------------+------------------
//  input   | in_valid/in_ready, op, pos_x, pos_y, cell_*      | in_valid & in_ready
//  output  | out_valid/out_ready, is_valid, clearance_dist,   | out_valid & out_ready
//          | found                                            |
//  config  | cfg_we, cfg_index, cfg_data                      | cfg_we
//
// Op 0 and unused ops go straight to the result, op 1 reads one cell. Op 2
// walks the spiral, one grid RAM read and compare per point, then squares
// dx and dy and takes the bit-serial root when found.
// in_ready is high only in idle; a held result does not block a new transfer.
// Reset clears control state and sizes, sets obstacle class 1; the grid is undefined until written.
module grid_validity_clearance_search_core #(
    parameter int GRID_W = 256,
    parameter int GRID_H = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  op,
    input  logic signed [23:0]          pos_x,
    input  logic signed [23:0]          pos_y,
    input  logic [7:0]                  cell_x,
    input  logic [7:0]                  cell_y,
    input  logic [7:0]                  cell_class,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        is_valid,
    output logic signed [17:0]          clearance_dist,
    output logic                        found,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [8:0]                  cfg_data
);

    import gvcs_pkg::*;

    localparam int DEPTH = GRID_W * GRID_H;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(GRID_W);
    localparam int YW    = $clog2(GRID_H);

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]        size_x_reg, size_y_reg;
    logic [CLASS_W-1:0]       obst_reg;
    logic [1:0]               op_reg, op_next;
    logic signed [POS_W-1:0]  px_reg, px_next, py_reg, py_next;
    logic signed [OFF_W-1:0]  dx_reg, dx_next, dy_reg, dy_next;
    logic [SIZE_W-1:0]        ring_reg, ring_next, step_reg, step_next;
    logic                     phase_y_reg, phase_y_next;
    logic                     first_reg, first_next;
    logic                     start_reg, start_next;
    logic                     inr_reg, inr_next;
    logic                     found_reg, found_next;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    logic [RAD_W-1:0]         rad_reg, rad_next, root_reg, root_next, bit_reg, bit_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     is_valid_reg, is_valid_next;
    logic signed [DIST_W-1:0] dist_reg, dist_next;
    logic                     found_out_reg, found_out_next;

    logic [SIZE_W-1:0]        eff_x, eff_y, stop;
    logic signed [VAL_W-1:0]  vx, vy;
    logic                     x_in, y_in, in_range;
    logic [XW-1:0]            cx;
    logic [YW-1:0]            cy;
    logic [AW-1:0]            raddr, waddr;
    logic                     we;
    logic [CLASS_W-1:0]       rdata;
    logic                     cur_valid;
    logic signed [OFF_W-1:0]  dir, mul_a;
    logic signed [2*OFF_W-1:0] prod;
    logic [RAD_W-1:0]         trial;
    logic [RAD_W-1:0]         dist_mag;
    logic [SIZE_W-1:0]        step_inc, ring_inc;

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= '0;
            size_y_reg <= '0;
            obst_reg   <= CLASS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIZE_X:   size_x_reg <= cfg_data;
                CFG_SIZE_Y:   size_y_reg <= cfg_data;
                CFG_OBSTACLE: obst_reg   <= cfg_data[CLASS_W-1:0];
                default:      ;
            endcase
        end
    end

    assign eff_x = ({4'b0, size_x_reg} > 13'(GRID_W)) ? SIZE_W'(GRID_W) : size_x_reg;
    assign eff_y = ({4'b0, size_y_reg} > 13'(GRID_H)) ? SIZE_W'(GRID_H) : size_y_reg;
    assign stop  = (eff_x > eff_y) ? eff_x : eff_y;

    // ---- cell lookup: round by adding one half, truncate toward zero ----
    assign vx = VAL_W'(px_reg) + VAL_W'(128) + {{(VAL_W-OFF_W-8){dx_reg[OFF_W-1]}}, dx_reg, 8'b0};
    assign vy = VAL_W'(py_reg) + VAL_W'(128) + {{(VAL_W-OFF_W-8){dy_reg[OFF_W-1]}}, dy_reg, 8'b0};

    // a value just below zero still truncates to cell 0
    assign x_in = vx[VAL_W-1] ? ((&vx[VAL_W-1:8]) && (vx[7:0] != 8'd0))
                              : (vx[VAL_W-1:8] < (VAL_W-8)'(eff_x));
    assign y_in = vy[VAL_W-1] ? ((&vy[VAL_W-1:8]) && (vy[7:0] != 8'd0))
                              : (vy[VAL_W-1:8] < (VAL_W-8)'(eff_y));
    assign in_range = (eff_x != '0) && (eff_y != '0) && x_in && y_in;

    assign cx    = vx[VAL_W-1] ? '0 : vx[8 +: XW];
    assign cy    = vy[VAL_W-1] ? '0 : vy[8 +: YW];
    assign raddr = AW'(AW'(cy) * AW'(GRID_W) + AW'(cx));
    assign waddr = AW'(AW'(cell_y) * AW'(GRID_W) + AW'(cell_x));
    assign we    = in_valid && in_ready && (op == OP_WRITE)
                   && ({5'b0, cell_x} < 13'(GRID_W)) && ({5'b0, cell_y} < 13'(GRID_H));

    gvcs_ram #(
        .WIDTH(CLASS_W),
        .DEPTH(DEPTH)
    ) u_grid (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(cell_class),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign cur_valid = inr_reg && (rdata != obst_reg);
    assign dir       = ring_reg[0] ? OFF_W'(1) : -OFF_W'(1);
    assign step_inc  = step_reg + SIZE_W'(1);
    assign ring_inc  = ring_reg + SIZE_W'(1);

    // shared squarer for dx then dy
    assign mul_a = (state_reg == S_SQX) ? dx_reg : dy_reg;
    assign prod  = mul_a * mul_a;
    assign trial = root_reg + bit_reg;

    assign dist_mag = (root_reg + RAD_W'(1)) >> 1;

    // ---- sequencer ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            ring_reg      <= '0;
            step_reg      <= '0;
            phase_y_reg   <= 1'b0;
            first_reg     <= 1'b0;
            start_reg     <= 1'b0;
            inr_reg       <= 1'b0;
            found_reg     <= 1'b0;
            sq_reg        <= '0;
            rad_reg       <= '0;
            root_reg      <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
            is_valid_reg  <= 1'b0;
            dist_reg      <= '0;
            found_out_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            ring_reg      <= ring_next;
            step_reg      <= step_next;
            phase_y_reg   <= phase_y_next;
            first_reg     <= first_next;
            start_reg     <= start_next;
            inr_reg       <= inr_next;
            found_reg     <= found_next;
            sq_reg        <= sq_next;
            rad_reg       <= rad_next;
            root_reg      <= root_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
            is_valid_reg  <= is_valid_next;
            dist_reg      <= dist_next;
            found_out_reg <= found_out_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        ring_next      = ring_reg;
        step_next      = step_reg;
        phase_y_next   = phase_y_reg;
        first_next     = first_reg;
        start_next     = start_reg;
        inr_next       = inr_reg;
        found_next     = found_reg;
        sq_next        = sq_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        is_valid_next  = is_valid_reg;
        dist_next      = dist_reg;
        found_out_next = found_out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = op;
                    px_next    = pos_x;
                    py_next    = pos_y;
                    dx_next    = '0;
                    dy_next    = '0;
                    first_next = 1'b1;
                    start_next = 1'b0;
                    found_next = 1'b0;
                    if (op == OP_CHECK || op == OP_SEARCH)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_RD:
            begin
                inr_next   = in_range;
                state_next = S_CHK;
            end

            S_CHK:
            begin
                if (first_reg)
                begin
                    first_next = 1'b0;
                    start_next = cur_valid;
                    if (op_reg == OP_CHECK || stop <= SIZE_W'(1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ring_next    = SIZE_W'(1);
                        step_next    = '0;
                        phase_y_next = 1'b0;
                        dx_next      = OFF_W'(1);
                        state_next   = S_RD;
                    end
                end
                else if (cur_valid != start_reg)
                begin
                    found_next = 1'b1;
                    state_next = S_SQX;
                end
                else if (step_inc != ring_reg)
                begin
                    step_next  = step_inc;
                    state_next = S_RD;
                    if (phase_y_reg)
                    begin
                        dy_next = dy_reg + dir;
                    end
                    else
                    begin
                        dx_next = dx_reg + dir;
                    end
                end
                else if (!phase_y_reg)
                begin
                    // turn from the x leg to the y leg of this ring
                    phase_y_next = 1'b1;
                    step_next    = '0;
                    dy_next      = dy_reg + dir;
                    state_next   = S_RD;
                end
                else if (ring_inc == stop)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // next ring flips direction
                    ring_next    = ring_inc;
                    phase_y_next = 1'b0;
                    step_next    = '0;
                    dx_next      = dx_reg - dir;
                    state_next   = S_RD;
                end
            end

            S_SQX:
            begin
                sq_next    = SQ_W'(prod);
                state_next = S_SQY;
            end

            S_SQY:
            begin
                rad_next   = RAD_W'(sq_reg + SQ_W'(prod)) << RAD_SH;
                root_next  = '0;
                bit_next   = RAD_W'(1) << (RAD_W - 2);
                state_next = S_SQRT;
            end

            S_SQRT:
            begin
                if (bit_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    if (rad_reg >= trial)
                    begin
                        rad_next  = rad_reg - trial;
                        root_next = (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_next = root_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    is_valid_next  = (op_reg == OP_CHECK || op_reg == OP_SEARCH) && start_reg;
                    found_out_next = found_reg;
                    if (!found_reg)
                    begin
                        dist_next = '0;
                    end
                    else if (start_reg)
                    begin
                        dist_next = dist_mag[DIST_W-1:0];
                    end
                    else
                    begin
                        dist_next = -dist_mag[DIST_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign is_valid       = is_valid_reg;
    assign clearance_dist = dist_reg;
    assign found          = found_out_reg;

    // ---- checks ----
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a second item while busy");

    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (clearance_dist != '0))
        else $error("found result with zero distance");

    a_invalid_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_valid && found) |-> clearance_dist[DIST_W-1])
        else $error("invalid start with non-negative distance");

    a_spiral_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD && !first_reg) |-> (ring_reg != '0) && (ring_reg < stop))
        else $error("spiral ring out of bounds");

endmodule

// File: design/gvcs_ram.sv
// ----------------------------------------------------------------------------
// gvcs_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gvcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: dv/tb_grid_validity_clearance_search_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_validity_clearance_search_core: self-checking bench for the core
// Writes class grids, runs validity checks and spiral clearance searches under
// several register settings and handshake idling, and compares every result
// against an in-bench predictor of grid, registers and spiral walk.
// ----------------------------------------------------------------------------
module tb_grid_validity_clearance_search_core;

    import gvcs_pkg::*;

    localparam int GW         = 256;
    localparam int GH         = 256;
    localparam int STALL_MAX  = 1000000;
    localparam int DRAIN_CYC  = 8;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct {
        logic                     valid_bit;
        logic signed [DIST_W-1:0] dist_val;
        logic                     hit;
    } answer_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               op;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [CELL_W-1:0]        cell_x;
    logic [CELL_W-1:0]        cell_y;
    logic [CLASS_W-1:0]       cell_class;
    logic                     out_valid;
    logic                     out_ready;
    logic                     is_valid;
    logic signed [DIST_W-1:0] clearance_dist;
    logic                     found;
    logic                     cfg_we;
    logic [1:0]               cfg_index;
    logic [SIZE_W-1:0]        cfg_data;

    // predictor copy of grid and registers
    logic [CLASS_W-1:0] grid_cls [GW*GH];
    int unsigned        width_q;
    int unsigned        height_q;
    logic [CLASS_W-1:0] obst_q;

    answer_t answer_q[$];
    int      err_cnt;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_off_cnt;
    int      quiet_cyc;

    grid_validity_clearance_search_core #(.GRID_W(GW), .GRID_H(GH)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .pos_x(pos_x), .pos_y(pos_y),
        .cell_x(cell_x), .cell_y(cell_y), .cell_class(cell_class),
        .out_valid(out_valid), .out_ready(out_ready),
        .is_valid(is_valid), .clearance_dist(clearance_dist), .found(found),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint eff_w();
        return (width_q > GW) ? GW : width_q;
    endfunction

    function automatic longint eff_h();
        return (height_q > GH) ? GH : height_q;
    endfunction

    function automatic longint round_cell(longint p);
        longint v;
        v = p + 128;
        if (v >= 0)
            return v >>> 8;
        return -((-v) >>> 8);
    endfunction

    function automatic bit point_clear(longint px, longint py);
        longint cx;
        longint cy;
        if (eff_w() == 0 || eff_h() == 0)
            return 0;
        cx = round_cell(px);
        cy = round_cell(py);
        if (cx < 0 || cx >= eff_w() || cy < 0 || cy >= eff_h())
            return 0;
        return grid_cls[cy*GW + cx] != obst_q;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic answer_t predict_query(logic [1:0] code, longint px, longint py);
        answer_t a;
        bit      start;
        longint  stop_ring;
        longint  dx;
        longint  dy;
        longint  step_dir;
        longint  d;
        bit      hit;
        a.valid_bit = 0;
        a.dist_val  = '0;
        a.hit       = 0;
        if (code == OP_CHECK) begin
            a.valid_bit = point_clear(px, py);
        end else if (code == OP_SEARCH) begin
            start     = point_clear(px, py);
            stop_ring = (eff_w() > eff_h()) ? eff_w() : eff_h();
            dx  = 0;
            dy  = 0;
            hit = 0;
            for (longint i = 1; i < stop_ring && !hit; i++) begin
                step_dir = (i & 1) ? 1 : -1;
                for (longint k = 0; k < i && !hit; k++) begin
                    dx += step_dir;
                    if (point_clear(px + dx*256, py + dy*256) != start)
                        hit = 1;
                end
                for (longint k = 0; k < i && !hit; k++) begin
                    dy += step_dir;
                    if (point_clear(px + dx*256, py + dy*256) != start)
                        hit = 1;
                end
            end
            a.valid_bit = start;
            a.hit       = hit;
            if (hit) begin
                d = longint'((int_sqrt(longint'(dx*dx + dy*dy) * 4 * 65536) + 1) >> 1);
                if (!start)
                    d = -d;
                a.dist_val = d[DIST_W-1:0];
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    // one input transfer; returns in the time step of acceptance with valid still high
    task automatic send_item(input logic [1:0] code, input int px, input int py,
                             input logic [7:0] cx, input logic [7:0] cy,
                             input logic [7:0] cls);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= code;
        pos_x      <= px[POS_W-1:0];
        pos_y      <= py[POS_W-1:0];
        cell_x     <= cx;
        cell_y     <= cy;
        cell_class <= cls;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (code == OP_WRITE)
            grid_cls[int'(cy)*GW + int'(cx)] = cls;
        answer_q.insert(answer_q.size(),
                        predict_query(code, longint'($signed(px[POS_W-1:0])),
                                      longint'($signed(py[POS_W-1:0]))));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_SIZE_X)
            width_q = val;
        else if (idx == CFG_SIZE_Y)
            height_q = val;
        else
            obst_q = val[7:0];
    endtask

    task automatic set_sizes(input logic [8:0] sx, input logic [8:0] sy);
        wait_idle();
        write_reg(CFG_SIZE_X, sx);
        write_reg(CFG_SIZE_Y, sy);
    endtask

    // write every cell that the sizes in use can reach, some of them obstacles
    task automatic set_map(input logic [8:0] sx, input logic [8:0] sy, input int obst_pct);
        int w;
        int h;
        set_sizes(sx, sy);
        w = (sx > GW) ? GW : sx;
        h = (sy > GH) ? GH : sy;
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                send_item(OP_WRITE, 0, 0, x[7:0], y[7:0],
                          ($urandom_range(99) < obst_pct) ? obst_q : 8'($urandom));
    endtask

    function automatic int near_pos(longint extent);
        return int'($urandom_range(0, int'(extent + 2) * 256)) - 384;
    endfunction

    task automatic random_item();
        int sel;
        int px;
        int py;
        sel = $urandom_range(99);
        if ($urandom_range(99) < 85) begin
            px = near_pos(eff_w());
            py = near_pos(eff_h());
        end else begin
            px = $urandom;
            py = $urandom;
        end
        if (sel < 25)
            send_item(OP_WRITE, px, py, 8'($urandom), 8'($urandom),
                      $urandom_range(1) ? obst_q : 8'($urandom));
        else if (sel < 55)
            send_item(OP_CHECK, px, py, 8'($urandom), 8'($urandom), 8'($urandom));
        else if (sel < 95)
            send_item(OP_SEARCH, px, py, 8'($urandom), 8'($urandom), 8'($urandom));
        else
            send_item(OP_NONE, px, py, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic test_no_map();
        send_item(OP_CHECK, 0, 0, 0, 0, 0);
        send_item(OP_SEARCH, 128, 128, 0, 0, 0);
        send_item(OP_WRITE, 0, 0, 8'd0, 8'd0, 8'd0);
        send_item(OP_WRITE, 0, 0, 8'd255, 8'd255, 8'd255);
        send_item(OP_NONE, -1, -1, 8'd255, 8'd255, 8'd255);
        wait_idle();
        write_reg(CFG_SIZE_X, 9'd4);
        send_item(OP_SEARCH, 0, 0, 0, 0, 0);
    endtask

    task automatic test_directed_grid();
        wait_idle();
        write_reg(CFG_OBSTACLE, 9'd7);
        set_map(9'd4, 9'd4, 40);
        send_item(OP_WRITE, 0, 0, 8'd1, 8'd1, 8'd7);
        send_item(OP_CHECK, 127, 0, 0, 0, 0);        // rounds down to cell 0
        send_item(OP_CHECK, 128, 128, 0, 0, 0);      // rounds up to cell 1
        send_item(OP_CHECK, -129, 0, 0, 0, 0);       // truncates toward zero
        send_item(OP_CHECK, -384, 0, 0, 0, 0);       // left of the grid
        send_item(OP_CHECK, 4*256, 0, 0, 0, 0);      // right of the grid
        send_item(OP_CHECK, 24'sh7FFFFF, -24'sh800000, 0, 0, 0);
        send_item(OP_SEARCH, 256, 256, 0, 0, 0);     // obstacle start
        send_item(OP_SEARCH, 0, 0, 0, 0, 0);
        send_item(OP_SEARCH, -24'sh800000, 24'sh7FFFFF, 0, 0, 0);
        send_item(OP_SEARCH, 3*256 + 100, 3*256 - 100, 0, 0, 0);
        // all clear: the search ends with nothing found
        set_map(9'd3, 9'd3, 0);
        send_item(OP_SEARCH, 256, 256, 0, 0, 0);
    endtask

    task automatic test_random(input int n, input int idle_pct, input int stall_pct);
        set_map(9'($urandom_range(1, 3)), 9'($urandom_range(1, 3)), 35);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
            random_item();
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_extreme_sizes();
        wait_idle();
        write_reg(CFG_OBSTACLE, 9'd0);
        // a width above the grid is clamped to the grid
        set_sizes(9'd511, 9'd1);
        for (int x = 250; x < 256; x++)
            send_item(OP_WRITE, 0, 0, x[7:0], 8'd0, 8'd9);
        send_item(OP_WRITE, 0, 0, 8'd252, 8'd0, 8'd0);
        send_item(OP_SEARCH, 255*256, 0, 0, 0, 0);
        send_item(OP_SEARCH, 252*256, 0, 0, 0, 0);
        send_item(OP_CHECK, 255*256 + 127, 0, 0, 0, 0);
        wait_idle();
        write_reg(CFG_OBSTACLE, 9'd255);
        set_sizes(9'd1, 9'd256);
        send_item(OP_WRITE, 0, 0, 8'd0, 8'd200, 8'd3);
        send_item(OP_WRITE, 0, 0, 8'd0, 8'd255, 8'd255);
        send_item(OP_SEARCH, 0, 200*256, 0, 0, 0);
        send_item(OP_CHECK, 0, 255*256, 0, 0, 0);
        // start far off the map: the walk runs the whole spiral
        send_item(OP_SEARCH, 0, -2000*256, 0, 0, 0);
        wait_idle();
        write_reg(CFG_OBSTACLE, 9'd1);
    endtask

    task automatic test_pressure();
        set_map(9'd3, 9'd3, 30);
        hold_off_cnt = 300;
        for (int i = 0; i < 12; i++)
            random_item();
    endtask

    // result side: stall, hold off, and compare each transfer
    always @(posedge clk) begin
        answer_t want;
        if (hold_off_cnt > 0) begin
            hold_off_cnt <= hold_off_cnt - 1;
            out_ready    <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (rst_n && out_valid && out_ready) begin
            if (answer_q.size() == 0) begin
                report_mismatch("unexpected result, is_valid", is_valid, 0);
            end else begin
                want = answer_q.pop_front();
                if (is_valid !== want.valid_bit)
                    report_mismatch("is_valid", is_valid, want.valid_bit);
                if (clearance_dist !== want.dist_val)
                    report_mismatch("clearance_dist", clearance_dist, want.dist_val);
                if (found !== want.hit)
                    report_mismatch("found", found, want.hit);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc > STALL_MAX) begin
            $display("tb_grid_validity_clearance_search_core NOT OK");
            $finish;
        end
    end

    initial begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        op             = OP_WRITE;
        pos_x          = '0;
        pos_y          = '0;
        cell_x         = '0;
        cell_y         = '0;
        cell_class     = '0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_SIZE_X;
        cfg_data       = '0;
        width_q        = 0;
        height_q       = 0;
        obst_q         = 8'd1;
        err_cnt        = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_cnt   = 0;
        quiet_cyc      = 0;
        for (int i = 0; i < GW*GH; i++)
            grid_cls[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_map();
        test_directed_grid();
        test_random(8, 0, 0);
        test_random(8, 56, 0);
        test_random(8, 0, 56);
        test_random(8, 31, 31);
        test_extreme_sizes();
        test_pressure();
        wait_idle();

        if (err_cnt == 0 && answer_q.size() == 0) begin
            $display("tb_grid_validity_clearance_search_core OK");
        end else begin
            if (answer_q.size() != 0)
                report_mismatch("results missing at end", 0, answer_q.size());
            $display("tb_grid_validity_clearance_search_core NOT OK");
        end
        $finish;
    end

endmodule

// File: grid_validity_clearance_search_core.f
design/gvcs_pkg.sv
design/gvcs_ram.sv
design/grid_validity_clearance_search_core.sv
dv/tb_grid_validity_clearance_search_core.sv
